// File: rtl/nmeachk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeachk_pkg
// Shared constants, result type and character helpers of the sentence checker.
// ----------------------------------------------------------------------------
package nmeachk_pkg;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;

    localparam logic [23:0] WORD_RMC = {8'h52, 8'h4D, 8'h43};
    localparam logic [23:0] WORD_GGA = {8'h47, 8'h47, 8'h41};
    localparam logic [23:0] WORD_GSA = {8'h47, 8'h53, 8'h41};

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RMC  = 2'd1;
    localparam logic [1:0] KIND_GGA  = 2'd2;
    localparam logic [1:0] KIND_GSA  = 2'd3;

    localparam int RESULT_W = 21;
    localparam int TDATA_W  = 24;

    typedef struct packed {
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic       line_overflow;
        logic       sentence_good;
        logic       checksum_ok;
        logic [1:0] sentence_kind;
    } result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

// File: rtl/nmeachk_line_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeachk_line_state
// Per-line tracking registers and the result for a byte that ends a line.
// ----------------------------------------------------------------------------
module nmeachk_line_state
    import nmeachk_pkg::*;
#(
    parameter int LINE_CAPACITY = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,        // consume rx_byte this cycle
    input  logic [7:0] rx_byte,
    output logic       res_valid,   // rx_byte ends the line
    output result_t    res
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LINE_CAPACITY - 1);

    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic             seen_dollar_reg, seen_dollar_next;
    logic             seen_star_reg, seen_star_next;
    logic             star_first_reg, star_first_next;
    logic [7:0]       running_xor_reg, running_xor_next;
    logic [1:0]       hex_taken_reg, hex_taken_next;
    logic             hex_stopped_reg, hex_stopped_next;
    logic [7:0]       hex_value_reg, hex_value_next;
    logic [7:0]       prev_char_reg, prev_char_next;
    logic [7:0]       prev_prev_reg, prev_prev_next;
    logic [2:0]       kind_flags_reg, kind_flags_next;

    logic       is_skip;
    logic       is_lf;
    logic       is_full;
    logic [1:0] kind;
    logic       sum_ok;
    logic [23:0] last3;

    assign is_skip = (rx_byte == CHAR_CR) || (rx_byte == CHAR_NUL);
    assign is_lf   = (rx_byte == CHAR_LF);
    assign is_full = (char_count_reg >= LAST_CNT);
    assign last3   = {prev_prev_reg, prev_char_reg, rx_byte};

    always_comb begin
        if (kind_flags_reg[0]) begin
            kind = KIND_RMC;
        end else if (kind_flags_reg[1]) begin
            kind = KIND_GGA;
        end else if (kind_flags_reg[2]) begin
            kind = KIND_GSA;
        end else begin
            kind = KIND_NONE;
        end
    end

    assign sum_ok = (char_count_reg != '0) && seen_dollar_reg && seen_star_reg
                    && !star_first_reg && (running_xor_reg == hex_value_reg);

    assign res_valid = !is_skip && (is_lf || is_full);

    always_comb begin
        res = '0;
        if (is_lf) begin
            res.sentence_kind = kind;
            res.checksum_ok   = sum_ok;
            res.sentence_good = sum_ok && (kind != KIND_NONE);
            res.computed_sum  = running_xor_reg;
            res.received_sum  = hex_value_reg;
        end else begin
            res.line_overflow = 1'b1;
        end
    end

    always_comb begin
        char_count_next  = char_count_reg;
        seen_dollar_next = seen_dollar_reg;
        seen_star_next   = seen_star_reg;
        star_first_next  = star_first_reg;
        running_xor_next = running_xor_reg;
        hex_taken_next   = hex_taken_reg;
        hex_stopped_next = hex_stopped_reg;
        hex_value_next   = hex_value_reg;
        prev_char_next   = prev_char_reg;
        prev_prev_next   = prev_prev_reg;
        kind_flags_next  = kind_flags_reg;
        if (step && !is_skip) begin
            if (is_lf || is_full) begin
                // end of line: start over
                char_count_next  = '0;
                seen_dollar_next = 1'b0;
                seen_star_next   = 1'b0;
                star_first_next  = 1'b0;
                running_xor_next = '0;
                hex_taken_next   = '0;
                hex_stopped_next = 1'b0;
                hex_value_next   = '0;
                prev_char_next   = '0;
                prev_prev_next   = '0;
                kind_flags_next  = '0;
            end else begin
                char_count_next = char_count_reg + 1'b1;
                if (seen_star_reg && !hex_stopped_reg && (hex_taken_reg < 2'd2)) begin
                    if (is_hex(rx_byte)) begin
                        hex_value_next = {hex_value_reg[3:0], hex_val(rx_byte)};
                        hex_taken_next = hex_taken_reg + 1'b1;
                    end else begin
                        hex_stopped_next = 1'b1;
                    end
                end
                if ((rx_byte == CHAR_STAR) && !seen_star_reg) begin
                    seen_star_next = 1'b1;
                    if (!seen_dollar_reg) begin
                        star_first_next = 1'b1;
                    end
                end else if ((rx_byte == CHAR_DOLLAR) && !seen_dollar_reg) begin
                    seen_dollar_next = 1'b1;
                end else if (seen_dollar_reg && !seen_star_reg) begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                end
                kind_flags_next = kind_flags_reg | {(last3 == WORD_GSA),
                                                    (last3 == WORD_GGA),
                                                    (last3 == WORD_RMC)};
                prev_prev_next = prev_char_reg;
                prev_char_next = rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg  <= '0;
            seen_dollar_reg <= 1'b0;
            seen_star_reg   <= 1'b0;
            star_first_reg  <= 1'b0;
            running_xor_reg <= '0;
            hex_taken_reg   <= '0;
            hex_stopped_reg <= 1'b0;
            hex_value_reg   <= '0;
            prev_char_reg   <= '0;
            prev_prev_reg   <= '0;
            kind_flags_reg  <= '0;
        end else begin
            char_count_reg  <= char_count_next;
            seen_dollar_reg <= seen_dollar_next;
            seen_star_reg   <= seen_star_next;
            star_first_reg  <= star_first_next;
            running_xor_reg <= running_xor_next;
            hex_taken_reg   <= hex_taken_next;
            hex_stopped_reg <= hex_stopped_next;
            hex_value_reg   <= hex_value_next;
            prev_char_reg   <= prev_char_next;
            prev_prev_reg   <= prev_prev_next;
            kind_flags_reg  <= kind_flags_next;
        end
    end

endmodule

// File: rtl/nmea_sentence_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Checks NMEA 0183 sentences byte by byte and reports one status per line.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one received character per request in s_tdata.
//   CR and NUL are ignored; LF closes the line and yields one status
//   request on the master channel (m_*). A line that reaches LINE_CAPACITY
//   bytes is dropped and yields a status with only line_overflow set.
//   Other bytes yield no output.
// Path: a closing byte passes the input register, then the result register,
//   before it shows up on m_tvalid.
// Throughput: one byte per cycle unless a closing byte waits on a busy result;
//   the line state (XOR, hex digits, keyword flags, length count) steps per byte.
// Reset: aresetn low clears both valid flags and the line state; the first
//   byte after reset starts a fresh line.
// Stall: while m_tready is low, the result is held in the output register;
//   bytes that end no line keep flowing, and a closing byte waits in the
//   input register, which then drops s_tready until the result is taken.
// ----------------------------------------------------------------------------
module nmea_sentence_checker
    import nmeachk_pkg::*;
#(
    parameter int LINE_CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] sentence_kind, [2] checksum_ok, [3] sentence_good, [4] line_overflow,
    // [12:5] computed_sum, [20:13] received_sum, [23:21] zero
    output logic [23:0] m_tdata
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       res_valid;
    result_t    res;
    logic       adv;

    // Advance the held byte unless it closes a line and the result slot is busy.
    assign adv      = in_valid_reg && (!res_valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    nmeachk_line_state #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_line_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (adv),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register: take a new byte when empty or when the held one moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result register: load on a line end, drop once the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - RESULT_W)'(0), out_res_reg};

`ifndef SYNTHESIS
    a_good_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.sentence_good |->
            out_res_reg.checksum_ok && (out_res_reg.sentence_kind != KIND_NONE))
        else $error("sentence_good set without a valid recognized sentence");

    a_overflow_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.line_overflow |->
            (out_res_reg.sentence_kind == KIND_NONE) && !out_res_reg.checksum_ok
            && (out_res_reg.computed_sum == 8'h00) && (out_res_reg.received_sum == 8'h00))
        else $error("overflow status carries line data");

    a_load_only_on_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && res_valid |-> !out_valid_reg || m_tready)
        else $error("result loaded over an untaken result");

    a_held_byte_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled byte lost or changed");
`endif

endmodule
